>>> rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse core.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int NUM_ELEM   = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int MUL_CHUNK  = 32;

  typedef logic [3:0] idx_t;

  // cofactor e = m[P]*m[Q] - m[R]*m[S], row-major element indexes
  localparam idx_t COF_P [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t COF_Q [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t COF_R [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
  localparam idx_t COF_S [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

>>> rtl/mi3_front.sv
// Front pipeline: cofactors, determinant and singular classification.
`timescale 1ns / 1ps
`default_nettype none
module mi3_front #(
  parameter int W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mi3_pkg::NUM_ELEM*W-1:0] in_data_i,
  input  mi3_pkg::fifo_stat_t           stat_i,
  output logic                          push_o,
  output logic [mi3_pkg::NUM_ELEM*(2*W+1)+9+3*W+3+2-1:0] push_data_o
);

  localparam int NE = mi3_pkg::NUM_ELEM;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic       en;
  logic [6:0] v_q;

  logic signed [W-1:0]    m0_q [NE];
  logic signed [2*W-1:0]  pa_q [NE];
  logic signed [2*W-1:0]  pb_q [NE];
  logic signed [W-1:0]    m1_q [3];
  logic signed [CW-1:0]   c2_q [NE];
  logic signed [W-1:0]    m2_q [3];
  logic signed [W:0]      clo  [3];
  logic signed [W:0]      chi  [3];
  logic signed [2*W:0]    lo3_q [3];
  logic signed [2*W:0]    hi3_q [3];
  logic [CW-1:0]          cm3_q [NE];
  logic [NE-1:0]          cs3_q;
  logic signed [DW-1:0]   t4_q [3];
  logic [CW-1:0]          cm4_q [NE];
  logic [NE-1:0]          cs4_q;
  logic signed [DW-1:0]   det5_q;
  logic [CW-1:0]          cm5_q [NE];
  logic [NE-1:0]          cs5_q;
  logic [DW-1:0]          dabs6_q;
  logic                   dneg6_q;
  logic                   sing6_q;
  logic [NE*CW-1:0]       cm6_q;
  logic [NE-1:0]          cs6_q;

  assign en         = !(v_q[6] && stat_i.full);
  assign in_ready_o = en;
  assign push_o     = v_q[6] && !stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_split
    assign clo[k] = $signed({1'b0, c2_q[3*k][W-1:0]});
    assign chi[k] = $signed(c2_q[3*k][CW-1:W]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < NE; e++) begin
        m0_q[e] <= in_data_i[e*W +: W];
        pa_q[e] <= m0_q[mi3_pkg::COF_P[e]] * m0_q[mi3_pkg::COF_Q[e]];
        pb_q[e] <= m0_q[mi3_pkg::COF_R[e]] * m0_q[mi3_pkg::COF_S[e]];
        c2_q[e] <= pa_q[e] - pb_q[e];
        cm3_q[e] <= c2_q[e][CW-1] ? CW'(-c2_q[e]) : CW'(c2_q[e]);
        cm4_q[e] <= cm3_q[e];
        cm5_q[e] <= cm4_q[e];
        cm6_q[e*CW +: CW] <= cm5_q[e];
        cs3_q[e] <= c2_q[e][CW-1];
      end
      for (int k = 0; k < 3; k++) begin
        m1_q[k]  <= m0_q[k];
        m2_q[k]  <= m1_q[k];
        lo3_q[k] <= m2_q[k] * clo[k];
        hi3_q[k] <= m2_q[k] * chi[k];
        t4_q[k]  <= lo3_q[k] + (hi3_q[k] <<< W);
      end
      cs4_q   <= cs3_q;
      cs5_q   <= cs4_q;
      cs6_q   <= cs5_q;
      det5_q  <= t4_q[0] + t4_q[1] + t4_q[2];
      dabs6_q <= det5_q[DW-1] ? DW'(-det5_q) : DW'(det5_q);
      dneg6_q <= det5_q[DW-1];
      sing6_q <= (det5_q == '0);
    end
  end

  assign push_data_o = {sing6_q, dneg6_q, dabs6_q, cs6_q, cm6_q};

endmodule
`default_nettype wire

>>> rtl/mi3_fifo.sv
// Small register queue between the front and back pipelines.
`timescale 1ns / 1ps
`default_nettype none
module mi3_fifo #(
  parameter int DATA_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DATA_W-1:0]   data_i,
  input  logic                pop_i,
  output logic [DATA_W-1:0]   data_o,
  output mi3_pkg::fifo_stat_t stat_o
);

  localparam int AW = mi3_pkg::FIFO_AW;

  logic [DATA_W-1:0] mem_q [mi3_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;

  assign stat_o.full  = (cnt_q == (AW+1)'(mi3_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

>>> rtl/mi3_back.sv
// Back pipeline: reciprocal by restoring division, scaling, shift and saturation.
`timescale 1ns / 1ps
`default_nettype none
module mi3_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mi3_pkg::fifo_stat_t            stat_i,
  output logic                           pop_o,
  input  logic [mi3_pkg::NUM_ELEM*(2*W+1)+9+3*W+3+2-1:0] data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mi3_pkg::NUM_ELEM*W-1:0] out_data_o,
  output logic                           out_sing_o
);

  localparam int NE  = mi3_pkg::NUM_ELEM;
  localparam int MC  = mi3_pkg::MUL_CHUNK;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int RW  = DW + 1;
  localparam int QW  = 5 * F + 1;
  localparam int NCC = (CW + MC - 1) / MC;
  localparam int NCQ = (QW + MC - 1) / MC;
  localparam int CPW = NCC * MC;
  localparam int QPW = NCQ * MC;
  localparam int PRW = QPW + MC;
  localparam int TW  = CPW + QPW;
  localparam int PW  = CW + QW;
  localparam int SH  = 3 * F;
  localparam logic signed [PW:0] ONE  = 1;
  localparam logic signed [PW:0] MAXV = (ONE <<< (W - 1)) - ONE;
  localparam logic signed [PW:0] MINV = -(ONE <<< (W - 1));

  logic        en;
  logic [QW:0] dv_q;
  logic [3:0]  mv_q;

  logic [RW-1:0]    rem_q [QW+1];
  logic [QW-1:0]    quo_q [QW+1];
  logic [DW-1:0]    div_q [QW+1];
  logic [NE*CW-1:0] cm_q  [QW+1];
  logic [NE-1:0]    sg_q  [QW+1];
  logic             sn_q  [QW+1];

  logic [2*MC-1:0]  pp_q  [NE][NCC][NCQ];
  logic [PRW-1:0]   row_d [NE][NCC];
  logic [PRW-1:0]   row_q [NE][NCC];
  logic [TW-1:0]    tot_d [NE];
  logic [PW-1:0]    prod_q [NE];
  logic [NE-1:0]    sg1_q, sg2_q, sg3_q;
  logic             sn1_q, sn2_q, sn3_q;
  logic [CPW-1:0]   cpad [NE];
  logic [QPW-1:0]   qpad;
  logic signed [PW:0] sval [NE];
  logic signed [PW:0] shv  [NE];
  logic [W-1:0]     sat  [NE];
  logic [NE*W-1:0]  out_q;
  logic             out_sing_q;

  assign en          = !mv_q[3] || out_ready_i;
  assign pop_o       = en && !stat_i.empty;
  assign out_valid_o = mv_q[3];
  assign out_data_o  = out_q;
  assign out_sing_o  = out_sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      mv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[QW-1:0], !stat_i.empty};
      mv_q <= {mv_q[2:0], dv_q[QW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      cm_q[0]  <= data_i[NE*CW-1:0];
      sg_q[0]  <= data_i[NE*CW +: NE] ^ {NE{data_i[NE*CW+NE+DW]}};
      div_q[0] <= data_i[NE*CW+NE +: DW];
      sn_q[0]  <= data_i[NE*CW+NE+DW+1];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_q[s-1][RW-2:0], 1'(s == 1)};
    assign ge = (sh >= {1'b0, div_q[s-1]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s]        <= ge ? (sh - {1'b0, div_q[s-1]}) : sh;
        quo_q[s]        <= quo_q[s-1] | (QW'(ge) << (QW - s));
        div_q[s]        <= div_q[s-1];
        cm_q[s]         <= cm_q[s-1];
        sg_q[s]         <= sg_q[s-1];
        sn_q[s]         <= sn_q[s-1];
      end
    end
  end

  assign qpad = QPW'(quo_q[QW]);

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      cpad[e] = CPW'(cm_q[QW][e*CW +: CW]);
      for (int i = 0; i < NCC; i++) begin
        row_d[e][i] = '0;
        for (int j = 0; j < NCQ; j++) begin
          row_d[e][i] = row_d[e][i] + (PRW'(pp_q[e][i][j]) << (j * MC));
        end
      end
      tot_d[e] = '0;
      for (int i = 0; i < NCC; i++) begin
        tot_d[e] = tot_d[e] + (TW'(row_q[e][i]) << (i * MC));
      end
      sval[e] = sg3_q[e] ? -$signed({1'b0, prod_q[e]}) : $signed({1'b0, prod_q[e]});
      shv[e]  = sval[e] >>> SH;
      if (shv[e] > MAXV) begin
        sat[e] = MAXV[W-1:0];
      end else if (shv[e] < MINV) begin
        sat[e] = MINV[W-1:0];
      end else begin
        sat[e] = shv[e][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < NE; e++) begin
        for (int i = 0; i < NCC; i++) begin
          for (int j = 0; j < NCQ; j++) begin
            pp_q[e][i][j] <= cpad[e][i*MC +: MC] * qpad[j*MC +: MC];
          end
          row_q[e][i] <= row_d[e][i];
        end
        prod_q[e]       <= tot_d[e][PW-1:0];
        out_q[e*W +: W] <= sn3_q ? '0 : sat[e];
      end
      sg1_q      <= sg_q[QW];
      sg2_q      <= sg1_q;
      sg3_q      <= sg2_q;
      sn1_q      <= sn_q[QW];
      sn2_q      <= sn1_q;
      sn3_q      <= sn2_q;
      out_sing_q <= sn3_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/matrix_inverse_3x3_core.sv
// Throughput: one matrix per cycle unless m_axis_tready back-pressures the output;
// the reciprocal pipeline retires one quotient bit per stage over 5*FRAC_BITS+1
// stages, which sets the latency.
// Reset: rst_ni clears valid bits and queue pointers; datapath registers hold.
// Top level: 3x3 matrix inverse by adjugate in signed fixed point.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_core #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a00 a01 a02 a10 a11 a12 a20 a21 a22, zero padded to bytes
  input  logic [((mi3_pkg::NUM_ELEM*WORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22, zero padded to bytes
  output logic [((mi3_pkg::NUM_ELEM*WORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular
  output logic m_axis_tuser
);

  localparam int NE  = mi3_pkg::NUM_ELEM;
  localparam int TDW = ((NE * WORD_WIDTH + 7) / 8) * 8;
  localparam int FW  = NE * (2 * WORD_WIDTH + 1) + 9 + 3 * WORD_WIDTH + 3 + 2;

  logic                 fifo_push, fifo_pop;
  logic [FW-1:0]        push_data, pop_data;
  mi3_pkg::fifo_stat_t  fifo_stat;
  logic [NE*WORD_WIDTH-1:0] res_data;

  mi3_front #(.W(WORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[NE*WORD_WIDTH-1:0]),
    .stat_i      (fifo_stat),
    .push_o      (fifo_push),
    .push_data_o (push_data)
  );

  mi3_fifo #(.DATA_W(FW)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .data_i (push_data),
    .pop_i  (fifo_pop),
    .data_o (pop_data),
    .stat_o (fifo_stat)
  );

  mi3_back #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (fifo_stat),
    .pop_o       (fifo_pop),
    .data_i      (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_data),
    .out_sing_o  (m_axis_tuser)
  );

  assign m_axis_tdata = TDW'(res_data);

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("singular result carries nonzero data");

  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !fifo_pop)
    else $error("queue popped while output stalled");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_stat.full)
    else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire
